// ----- design/q16fx_pkg.sv -----
// Shared constants, operation codes and side-band type for the 16.16 fixed-point unit.
package q16fx_pkg;

  // Operation codes carried on in_req_type
  localparam logic [1:0] OP_DIV = 2'd0;
  localparam logic [1:0] OP_MUL = 2'd1;
  localparam logic [1:0] OP_F2L = 2'd2;
  localparam logic [1:0] OP_L2F = 2'd3;

  // Fixed-point format and saturation values
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned DVD_BITS  = WORD_BITS + FRAC_BITS;  // scaled dividend / quotient
  localparam int unsigned DIV_STEPS = DVD_BITS;                // one quotient bit per stage

  localparam logic [WORD_BITS-1:0] SAT_POS   = 32'h7FFF_FFFF;
  localparam logic [WORD_BITS-1:0] SAT_NEG   = 32'h8000_0000;
  localparam logic [WORD_BITS-1:0] HALF_UNIT = 32'h0000_8000;

  // Per-beat information that rides alongside the divider
  typedef struct packed {
    logic [1:0]           op;     // operation code
    logic [WORD_BITS-1:0] res;    // finished result for non-divide operations
    logic                 neg;    // quotient sign
    logic                 bzero;  // divisor was zero
  } side_t;

endpackage

// ----- design/q16_fixed_point_arith_unit.sv -----
// Top level of the signed 16.16 fixed-point divide / multiply / convert unit.
//
// Input channel: in_valid, in_stall, in_req_type, in_operand_a, in_operand_b.
// Result channel: out_valid, out_stall, out_result_value, out_div_saturated.
// A beat moves on a rising edge where valid is high and stall is low.
// Every input beat gives exactly one result beat, in order.
// Every operation passes through the operand stage, the conversion stage, the
// 48-stage restoring divider (one quotient bit per stage) and the output
// register, so all operations take the same path and results stay ordered.
// Throughput: one beat per cycle while the receiver takes results.
// The multiply forms two 32x16 partial products in the operand stage and
// sums them in the conversion stage.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall is raised in the same cycle; nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears every valid bit; payloads are not reset.
module q16_fixed_point_arith_unit
  import q16fx_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_req_type,
  input  logic signed [WORD_BITS-1:0] in_operand_a,
  input  logic signed [WORD_BITS-1:0] in_operand_b,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [WORD_BITS-1:0] out_result_value,
  output logic                        out_div_saturated
);

  // global advance: hold everything while the output beat is stalled
  logic out_valid_r;
  logic en;
  assign en       = ~(out_valid_r & out_stall);
  assign in_stall = ~en;

  // ---------------------------------------------------------------------
  // Stage 1: magnitudes, signs and the two partial products
  logic signed [WORD_BITS+FRAC_BITS:0]   pp_lo;  // a times the low half of b
  logic signed [WORD_BITS+FRAC_BITS-1:0] pp_hi;  // a times the signed high half of b
  logic [WORD_BITS-1:0]                  ma;
  logic [WORD_BITS-1:0]                  mb;

  assign pp_lo = (WORD_BITS+FRAC_BITS+1)'(in_operand_a) *
                 (WORD_BITS+FRAC_BITS+1)'($signed({1'b0, in_operand_b[FRAC_BITS-1:0]}));
  assign pp_hi = (WORD_BITS+FRAC_BITS)'(in_operand_a) *
                 (WORD_BITS+FRAC_BITS)'($signed(in_operand_b[WORD_BITS-1:FRAC_BITS]));
  assign ma   = in_operand_a[WORD_BITS-1] ? (WORD_BITS)'(-in_operand_a) : in_operand_a;
  assign mb   = in_operand_b[WORD_BITS-1] ? (WORD_BITS)'(-in_operand_b) : in_operand_b;

  logic                 s1_vld_r;
  logic [1:0]           s1_op_r;
  logic [WORD_BITS-1:0] s1_a_r;
  logic [WORD_BITS-1:0] s1_ma_r;
  logic [WORD_BITS-1:0] s1_mb_r;
  logic                 s1_neg_r;
  logic                 s1_bzero_r;
  logic [WORD_BITS-1:0] s1_plo_r;
  logic [WORD_BITS-1:0] s1_phi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op_r    <= in_req_type;
      s1_a_r     <= in_operand_a;
      s1_ma_r    <= ma;
      s1_mb_r    <= mb;
      s1_neg_r   <= in_operand_a[WORD_BITS-1] ^ in_operand_b[WORD_BITS-1];
      s1_bzero_r <= (in_operand_b == '0);
      s1_plo_r   <= pp_lo[WORD_BITS+FRAC_BITS-1:FRAC_BITS];
      s1_phi_r   <= pp_hi[WORD_BITS-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: finish the non-divide operations
  logic [WORD_BITS:0]           rnd_sum;
  logic [WORD_BITS-FRAC_BITS:0] rnd_mag;
  logic [WORD_BITS-1:0]         f2l_res;
  logic [WORD_BITS-1:0]         mul_res;
  logic [WORD_BITS-1:0]         res_nxt;

  // product bits 47..16: shifted low partial plus high partial, wrapped
  assign mul_res = s1_plo_r + s1_phi_r;

  assign rnd_sum = {1'b0, s1_ma_r} + {1'b0, HALF_UNIT};
  assign rnd_mag = rnd_sum[WORD_BITS:FRAC_BITS];
  assign f2l_res = s1_a_r[WORD_BITS-1] ? (WORD_BITS)'(-{{(FRAC_BITS-1){1'b0}}, rnd_mag})
                                       : {{(FRAC_BITS-1){1'b0}}, rnd_mag};

  always_comb begin
    unique case (s1_op_r)
      OP_MUL:  res_nxt = mul_res;
      OP_F2L:  res_nxt = f2l_res;
      OP_L2F:  res_nxt = {s1_a_r[WORD_BITS-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
      default: res_nxt = '0;
    endcase
  end

  logic                 s2_vld_r;
  logic [WORD_BITS-1:0] s2_ma_r;
  logic [WORD_BITS-1:0] s2_mb_r;
  side_t                s2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ma_r         <= s1_ma_r;
      s2_mb_r         <= s1_mb_r;
      s2_side_r.op    <= s1_op_r;
      s2_side_r.res   <= res_nxt;
      s2_side_r.neg   <= s1_neg_r;
      s2_side_r.bzero <= s1_bzero_r;
    end
  end

  // ---------------------------------------------------------------------
  // Divider pipeline
  logic                div_vld;
  logic [DVD_BITS-1:0] div_q;
  side_t               div_side;

  q16fx_div_pipe u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s2_vld_r),
    .in_ma    (s2_ma_r),
    .in_mb    (s2_mb_r),
    .in_side  (s2_side_r),
    .out_vld  (div_vld),
    .out_q    (div_q),
    .out_side (div_side)
  );

  // ---------------------------------------------------------------------
  // Output stage: sign and saturation of the quotient; non-divide results pass through
  logic                 q_hi_any;
  logic                 pos_ovf;
  logic                 neg_ovf;
  logic [WORD_BITS-1:0] fin_res;
  logic                 fin_sat;

  assign q_hi_any = |div_q[DVD_BITS-1:WORD_BITS];
  assign pos_ovf  = q_hi_any | div_q[WORD_BITS-1];
  assign neg_ovf  = q_hi_any | (div_q[WORD_BITS-1] & (|div_q[WORD_BITS-2:0]));

  always_comb begin
    priority if (div_side.op != OP_DIV) begin
      fin_res = div_side.res;
      fin_sat = 1'b0;
    end else if (div_side.bzero) begin
      fin_res = SAT_POS;
      fin_sat = 1'b1;
    end else if (!div_side.neg) begin
      fin_res = pos_ovf ? SAT_POS : div_q[WORD_BITS-1:0];
      fin_sat = pos_ovf;
    end else begin
      fin_res = neg_ovf ? SAT_NEG : (WORD_BITS)'(-div_q[WORD_BITS-1:0]);
      fin_sat = neg_ovf;
    end
  end

  logic [WORD_BITS-1:0] out_result_value_r;
  logic                 out_div_saturated_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_result_value_r  <= fin_res;
      out_div_saturated_r <= fin_sat;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_value  = out_result_value_r;
  assign out_div_saturated = out_div_saturated_r;

`ifndef ASSERT_OFF
  // a divide by zero always leaves as positive saturation with the flag
  a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (div_vld && en && div_side.op == OP_DIV && div_side.bzero) |=>
      (out_result_value_r == SAT_POS && out_div_saturated_r))
    else $error("divide by zero did not saturate");

  // a result only appears when the divider delivered a beat
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(div_vld))
    else $error("output beat without a source beat");

  // a held pipeline keeps its operand stage intact
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !en) |=> (s1_vld_r && $stable(s1_a_r) && $stable(s1_op_r)))
    else $error("operand stage changed while stalled");

  // the saturation flag is never raised for a non-divide operation
  a_sat_div: assert property (@(posedge clk) disable iff (!rst_n)
    (div_vld && en && div_side.op != OP_DIV) |=> !out_div_saturated_r)
    else $error("saturation flag on a non-divide beat");
`endif

endmodule

// ----- design/q16fx_div_pipe.sv -----
// Pipelined restoring divider: one quotient bit per register stage, side-band carried along.
module q16fx_div_pipe
  import q16fx_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [WORD_BITS-1:0] in_ma,
  input  logic [WORD_BITS-1:0] in_mb,
  input  side_t                in_side,
  output logic                 out_vld,
  output logic [DVD_BITS-1:0]  out_q,
  output side_t                out_side
);

  logic                 vld_r  [DIV_STEPS];
  logic [WORD_BITS-1:0] rem_r  [DIV_STEPS];
  logic [DVD_BITS-1:0]  dq_r   [DIV_STEPS];
  logic [WORD_BITS-1:0] mb_r   [DIV_STEPS];
  side_t                side_r [DIV_STEPS];

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    logic                 vld_in;
    logic [WORD_BITS-1:0] rem_in;
    logic [DVD_BITS-1:0]  dq_in;
    logic [WORD_BITS-1:0] mb_in;
    side_t                side_in;
    logic [WORD_BITS:0]   trial;
    logic [WORD_BITS:0]   diff;
    logic                 q_bit;
    logic [WORD_BITS-1:0] rem_nxt;
    logic [DVD_BITS-1:0]  dq_nxt;

    // stage source: pipe input for the first step, previous step otherwise
    if (s == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = '0;
      assign dq_in   = {in_ma, {FRAC_BITS{1'b0}}};
      assign mb_in   = in_mb;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign dq_in   = dq_r[s-1];
      assign mb_in   = mb_r[s-1];
      assign side_in = side_r[s-1];
    end

    // one restoring step: bring down a dividend bit, subtract if it fits
    assign trial   = {rem_in, dq_in[DVD_BITS-1]};
    assign diff    = trial - {1'b0, mb_in};
    assign q_bit   = ~diff[WORD_BITS];
    assign rem_nxt = q_bit ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
    assign dq_nxt  = {dq_in[DVD_BITS-2:0], q_bit};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        dq_r[s]   <= dq_nxt;
        mb_r[s]   <= mb_in;
        side_r[s] <= side_in;
      end
    end
  end

  assign out_vld  = vld_r[DIV_STEPS-1];
  assign out_q    = dq_r[DIV_STEPS-1];
  assign out_side = side_r[DIV_STEPS-1];

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the 16.16 fixed-point divide / multiply / convert unit.
`timescale 1ns / 100ps

module tb;
  import q16fx_pkg::*;

  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned LONG_HOLD_CYCLES = 150;
  localparam int unsigned DRAIN_CYCLES     = 60;   // a little over the pipeline latency

  // expected result of one beat
  typedef struct packed {
    logic [WORD_BITS-1:0] value;
    logic                 sat;
  } fx_result_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [1:0]                  in_req_type;
  logic signed [WORD_BITS-1:0] in_operand_a;
  logic signed [WORD_BITS-1:0] in_operand_b;
  logic                        out_valid;
  logic                        out_stall;
  logic signed [WORD_BITS-1:0] out_result_value;
  logic                        out_div_saturated;

  fx_result_t  pending_results[$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  bit          tx_idle_on;
  bit          rx_idle_on;
  bit          hold_long_req;

  q16_fixed_point_arith_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_operand_a     (in_operand_a),
    .in_operand_b     (in_operand_b),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_div_saturated(out_div_saturated)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // runaway guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Predicts the result of one request
  function automatic fx_result_t fx_predict(logic [1:0] op, logic [WORD_BITS-1:0] a,
                                            logic [WORD_BITS-1:0] b);
    fx_result_t         r;
    logic [63:0]        mag_a;
    logic [63:0]        mag_b;
    logic [63:0]        quo;
    logic [63:0]        rnd;
    logic signed [63:0] sa;
    logic signed [63:0] sb;
    logic signed [63:0] prod;
    logic               neg;
    r.value = '0;
    r.sat   = 1'b0;
    // magnitudes as unsigned, so the most negative value maps to 2^31
    mag_a = {32'd0, a[31] ? (32'd0 - a) : a};
    mag_b = {32'd0, b[31] ? (32'd0 - b) : b};
    case (op)
      OP_DIV: begin
        if (b == '0) begin
          r.value = SAT_POS;
          r.sat   = 1'b1;
        end else begin
          neg = a[31] ^ b[31];
          quo = (mag_a << FRAC_BITS) / mag_b;
          if (!neg && quo > {32'd0, SAT_POS}) begin
            r.value = SAT_POS;
            r.sat   = 1'b1;
          end else if (neg && quo > {32'd0, SAT_NEG}) begin
            r.value = SAT_NEG;
            r.sat   = 1'b1;
          end else begin
            r.value = neg ? (32'd0 - quo[31:0]) : quo[31:0];
          end
        end
      end
      OP_MUL: begin
        sa      = {{32{a[31]}}, a};
        sb      = {{32{b[31]}}, b};
        prod    = sa * sb;
        r.value = prod[47:16];
      end
      OP_F2L: begin
        // round half away from zero on the magnitude, then restore the sign
        rnd     = (mag_a + {32'd0, HALF_UNIT}) >> FRAC_BITS;
        r.value = a[31] ? (32'd0 - rnd[31:0]) : rnd[31:0];
      end
      default: begin
        r.value = a << FRAC_BITS;
      end
    endcase
    return r;
  endfunction

  // Operand drawn from a mix of ranges that hit the interesting corners
  function automatic logic [WORD_BITS-1:0] fx_rand_operand();
    logic [WORD_BITS-1:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
      2: begin
        case ($urandom_range(0, 6))
          0: v = 32'h0000_0000;
          1: v = 32'h0000_0001;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'h7FFF_FFFF;
          4: v = 32'h8000_0000;
          5: v = 32'h0001_0000;
          default: v = 32'hFFFF_0000;
        endcase
      end
      3: v = {16'($urandom_range(0, 16'hFFFF)), 16'h8000};   // exact halves
      4: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = 32'd0 - v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Sends one beat after the sender's idle gap and records its expected result
  task automatic fx_send(logic [1:0] op, logic [WORD_BITS-1:0] a, logic [WORD_BITS-1:0] b);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 8) : 0;
    @(negedge clk);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results = {pending_results, fx_predict(op, a, b)};
  endtask

  task automatic fx_send_random();
    logic [1:0] op;
    op = 2'($urandom_range(0, 3));
    fx_send(op, fx_rand_operand(), fx_rand_operand());
  endtask

  // Drops valid and waits until every outstanding result has come back
  task automatic fx_wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    fx_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: result_value %h div_saturated %b",
               out_result_value, out_div_saturated);
        mismatches++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_result_value !== exp_r.value) begin
          $error("result_value mismatch: expected %h, got %h", exp_r.value, out_result_value);
          mismatches++;
        end
        if (out_div_saturated !== exp_r.sat) begin
          $error("div_saturated mismatch: expected %b, got %b", exp_r.sat, out_div_saturated);
          mismatches++;
        end
      end
    end
  end

  // Receiver: random stall before each beat, or one long hold on request
  initial begin
    int unsigned n;
    bit          held_long;
    held_long = 1'b0;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      n = rx_idle_on ? $urandom_range(0, 8) : 0;
      if (hold_long_req && !held_long) begin
        n         = LONG_HOLD_CYCLES;
        held_long = 1'b1;
      end
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic test_divide_corners();
    fx_send(OP_DIV, 32'h0001_0000, 32'h0001_0000);  // 1.0 / 1.0
    fx_send(OP_DIV, 32'h0000_0000, 32'h0000_0000);  // zero divisor
    fx_send(OP_DIV, 32'h8000_0000, 32'h0000_0000);  // zero divisor, negative dividend
    fx_send(OP_DIV, 32'h8000_0000, 32'h0000_0001);  // negative overflow
    fx_send(OP_DIV, 32'h8000_0000, 32'h0001_0000);  // quotient exactly the most negative
    fx_send(OP_DIV, 32'h7FFF_FFFF, 32'h0001_0000);  // quotient exactly the most positive
    fx_send(OP_DIV, 32'h8000_0000, 32'hFFFF_0000);  // min / -1.0 overflows positive
    fx_send(OP_DIV, 32'hFFFF_FFFF, 32'h0000_0003);  // truncation toward zero
    fx_send(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000);
  endtask

  task automatic test_multiply_corners();
    fx_send(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);  // wraps, no flag
    fx_send(OP_MUL, 32'h8000_0000, 32'h8000_0000);
    fx_send(OP_MUL, 32'h8000_0000, 32'hFFFF_0000);
    fx_send(OP_MUL, 32'hFFFF_FFFF, 32'h0000_0001);  // arithmetic shift of a small negative
    fx_send(OP_MUL, 32'h0001_8000, 32'hFFFE_8000);
  endtask

  task automatic test_convert_corners();
    fx_send(OP_F2L, 32'h0000_8000, $urandom);  // +0.5 rounds away from zero
    fx_send(OP_F2L, 32'hFFFF_8000, $urandom);  // -0.5 rounds away from zero
    fx_send(OP_F2L, 32'h0000_7FFF, $urandom);
    fx_send(OP_F2L, 32'h8000_0000, $urandom);
    fx_send(OP_F2L, 32'h7FFF_FFFF, $urandom);
    fx_send(OP_L2F, 32'h7FFF_FFFF, $urandom);  // wraps
    fx_send(OP_L2F, 32'h8000_0000, $urandom);
    fx_send(OP_L2F, 32'hFFFF_FFFF, $urandom);
    fx_send(OP_L2F, 32'h0000_8000, $urandom);
  endtask

  task automatic test_random_traffic(int unsigned count);
    repeat (count) fx_send_random();
  endtask

  // receiver holds off long enough for the pipeline to fill and stall the input
  task automatic test_output_backpressure();
    tx_idle_on    = 1'b0;
    rx_idle_on    = 1'b0;
    hold_long_req = 1'b1;
    repeat (120) fx_send_random();
    fx_wait_drained();
  endtask

  // bursts separated by a full drain
  task automatic test_sender_pause();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (4) begin
      repeat (10) fx_send_random();
      fx_wait_drained();
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = OP_DIV;
    in_operand_a  = '0;
    in_operand_b  = '0;
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;
    hold_long_req = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_divide_corners();
    test_multiply_corners();
    test_convert_corners();

    // random traffic under each mix of idling
    test_random_traffic(250);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_traffic(100);
    tx_idle_on = 1'b1;
    test_random_traffic(150);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    test_random_traffic(100);

    test_output_backpressure();
    test_sender_pause();

    fx_wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/q16fx_pkg.sv
design/q16fx_div_pipe.sv
design/q16_fixed_point_arith_unit.sv
bench/tb.sv
